/* hw/rtl/sha1de_pkg.sv */
// Shared types and constants for the SHA-1 digest engine.
`timescale 1ns / 1ps

package sha1de_pkg;

    localparam int ROUNDS    = 80;
    localparam int BLK_BITS  = 512;
    localparam int CNT_BITS  = 61;

    localparam logic [6:0] LAST_ROUND = 7'(ROUNDS - 1);

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [7:0] ZERO_BYTE = 8'h00;

    localparam logic [5:0] POS_LEN_LAST = 6'd55;
    localparam logic [5:0] POS_BLK_LAST = 6'd63;
    localparam logic [2:0] IDX_LAST     = 3'd4;

    localparam logic [31:0] K_0 = 32'h5a827999;
    localparam logic [31:0] K_1 = 32'h6ed9eba1;
    localparam logic [31:0] K_2 = 32'h8f1bbcdc;
    localparam logic [31:0] K_3 = 32'hca62c1d6;

    localparam logic [4:0][31:0] H_INIT = {
        32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LEN,
        ST_ROUND,
        ST_FOLD,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
    } work_t;

    typedef struct packed {
        logic [31:0] w0;
        logic [31:0] w2;
        logic [31:0] w8;
        logic [31:0] w13;
    } taps_t;

endpackage

/* hw/rtl/sha1de_round.sv */
// One SHA-1 compression round and schedule word, reused for all 80 rounds.
`timescale 1ns / 1ps

module sha1de_round
    import sha1de_pkg::*;
(
    input  work_t       work_in,
    input  taps_t       taps,
    input  logic [6:0]  rnd,
    output work_t       work_out,
    output logic [31:0] sched_word
);

    logic [31:0] mix;
    logic [31:0] f_val;
    logic [31:0] k_val;

    always_comb begin
        mix = taps.w13 ^ taps.w8 ^ taps.w2 ^ taps.w0;
        if (rnd < 7'd16) begin
            sched_word = taps.w0;
        end else begin
            sched_word = {mix[30:0], mix[31]};
        end

        priority if (rnd < 7'd20) begin
            f_val = work_in.d ^ (work_in.b & (work_in.c ^ work_in.d));
            k_val = K_0;
        end else if (rnd < 7'd40) begin
            f_val = work_in.b ^ work_in.c ^ work_in.d;
            k_val = K_1;
        end else if (rnd < 7'd60) begin
            f_val = (work_in.b & work_in.c) | ((work_in.b | work_in.c) & work_in.d);
            k_val = K_2;
        end else begin
            f_val = work_in.b ^ work_in.c ^ work_in.d;
            k_val = K_3;
        end

        work_out.a = {work_in.a[26:0], work_in.a[31:27]} + f_val + work_in.e
                     + k_val + sched_word;
        work_out.b = work_in.a;
        work_out.c = {work_in.b[1:0], work_in.b[31:2]};
        work_out.d = work_in.c;
        work_out.e = work_in.d;
    end

endmodule

/* hw/rtl/sha1_digest_engine_core.sv */
// SHA-1 digest engine: byte intake, padding sequencer and digest output.
// Data item: the 64th byte of a block starts 80 rounds and a fold, with intake stalled.
// Finish item: pad and length bytes go in one per cycle to the block end, each block
// is compressed (one extra block when fewer than 9 bytes remain), then 5 words.
// Throughput is set by the single shared round unit, one round per cycle.
// Reset (aresetn low, synchronous): chaining values to initial, count and position zero.
`timescale 1ns / 1ps

module sha1_digest_engine_core
    import sha1de_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic [2:0]  m_tuser,   // [2:0] word_index
    output logic        m_tlast
);

    state_t                state_reg, state_next;
    logic [BLK_BITS-1:0]   blk_reg, blk_next;
    logic [5:0]            pos_reg, pos_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic [63:0]           len_reg, len_next;
    logic [6:0]            rnd_reg, rnd_next;
    work_t                 work_reg, work_next;
    logic [4:0][31:0]      hash_reg, hash_next;
    logic [2:0]            idx_reg, idx_next;
    logic                  fin_reg, fin_next;
    logic                  lendone_reg, lendone_next;

    logic        s_acc;
    logic        m_acc;
    logic        shift_en;
    logic [7:0]  byte_in;
    taps_t       taps;
    work_t       rnd_out;
    logic [31:0] sched_word;

    assign s_acc = s_tvalid && s_tready;
    assign m_acc = m_tvalid && m_tready;

    assign taps.w0  = blk_reg[511:480];
    assign taps.w2  = blk_reg[447:416];
    assign taps.w8  = blk_reg[255:224];
    assign taps.w13 = blk_reg[95:64];

    sha1de_round u_round (
        .work_in    (work_reg),
        .taps       (taps),
        .rnd        (rnd_reg),
        .work_out   (rnd_out),
        .sched_word (sched_word)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    priority if (pos_reg == POS_BLK_LAST) begin
                        state_next = ST_ROUND;
                    end else if (s_tuser == KIND_FINISH && pos_reg == POS_LEN_LAST) begin
                        state_next = ST_LEN;
                    end else if (s_tuser == KIND_FINISH) begin
                        state_next = ST_PAD;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_PAD: begin
                priority if (pos_reg == POS_BLK_LAST) begin
                    state_next = ST_ROUND;
                end else if (pos_reg == POS_LEN_LAST) begin
                    state_next = ST_LEN;
                end else begin
                    state_next = ST_PAD;
                end
            end
            ST_LEN: begin
                if (pos_reg == POS_BLK_LAST) begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: begin
                if (rnd_reg == LAST_ROUND) begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD: begin
                priority if (!fin_reg) begin
                    state_next = ST_IDLE;
                end else if (lendone_reg) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_PAD;
                end
            end
            ST_OUT: begin
                if (m_acc && idx_reg == IDX_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = (state_reg == ST_IDLE);
        m_tvalid = (state_reg == ST_OUT);
        m_tdata  = hash_reg[idx_reg];
        m_tuser  = idx_reg;
        m_tlast  = (idx_reg == IDX_LAST);
    end

    always_comb begin
        shift_en = 1'b0;
        byte_in  = ZERO_BYTE;
        unique case (state_reg)
            ST_IDLE: begin
                shift_en = s_acc;
                byte_in  = (s_tuser == KIND_FINISH) ? PAD_BYTE : s_tdata;
            end
            ST_PAD: begin
                shift_en = 1'b1;
            end
            ST_LEN: begin
                shift_en = 1'b1;
                byte_in  = len_reg[63:56];
            end
            default: begin
                shift_en = 1'b0;
            end
        endcase

        blk_next     = blk_reg;
        pos_next     = pos_reg;
        cnt_next     = cnt_reg;
        len_next     = len_reg;
        fin_next     = fin_reg;
        lendone_next = lendone_reg;
        hash_next    = hash_reg;
        idx_next     = idx_reg;

        if (shift_en) begin
            blk_next = {blk_reg[BLK_BITS-9:0], byte_in};
            pos_next = pos_reg + 6'd1;
        end

        if (state_reg == ST_IDLE && s_acc) begin
            if (s_tuser == KIND_FINISH) begin
                fin_next     = 1'b1;
                lendone_next = 1'b0;
                len_next     = {cnt_reg, 3'b000};
            end else begin
                cnt_next = cnt_reg + CNT_BITS'(1);
            end
        end

        if (state_reg == ST_LEN) begin
            len_next = {len_reg[55:0], ZERO_BYTE};
            if (pos_reg == POS_BLK_LAST) begin
                lendone_next = 1'b1;
            end
        end

        if (state_reg == ST_ROUND) begin
            blk_next  = {blk_reg[BLK_BITS-33:0], sched_word};
            work_next = rnd_out;
            rnd_next  = rnd_reg + 7'd1;
        end else begin
            work_next.a = hash_reg[0];
            work_next.b = hash_reg[1];
            work_next.c = hash_reg[2];
            work_next.d = hash_reg[3];
            work_next.e = hash_reg[4];
            rnd_next    = 7'd0;
        end

        if (state_reg == ST_FOLD) begin
            hash_next[0] = hash_reg[0] + work_reg.a;
            hash_next[1] = hash_reg[1] + work_reg.b;
            hash_next[2] = hash_reg[2] + work_reg.c;
            hash_next[3] = hash_reg[3] + work_reg.d;
            hash_next[4] = hash_reg[4] + work_reg.e;
        end

        if (m_acc) begin
            if (idx_reg == IDX_LAST) begin
                idx_next     = 3'd0;
                hash_next    = H_INIT;
                cnt_next     = '0;
                fin_next     = 1'b0;
                lendone_next = 1'b0;
            end else begin
                idx_next = idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pos_reg     <= '0;
            cnt_reg     <= '0;
            rnd_reg     <= '0;
            hash_reg    <= H_INIT;
            idx_reg     <= '0;
            fin_reg     <= 1'b0;
            lendone_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            cnt_reg     <= cnt_next;
            rnd_reg     <= rnd_next;
            hash_reg    <= hash_next;
            idx_reg     <= idx_next;
            fin_reg     <= fin_next;
            lendone_reg <= lendone_next;
        end
    end

    always_ff @(posedge aclk) begin
        blk_reg  <= blk_next;
        len_reg  <= len_next;
        work_reg <= work_next;
    end

`ifndef SYNTHESIS
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("intake and digest output active together");

    a_round_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROUND) |-> (rnd_reg <= LAST_ROUND))
        else $error("round counter past last round");

    a_block_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_ROUND && state_next == ST_ROUND) |=> (pos_reg == 6'd0))
        else $error("compression started on a partial block");

    a_reinit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_acc && m_tlast) |=> (hash_reg == H_INIT && cnt_reg == '0 && !fin_reg))
        else $error("hash state not reinitialized after digest");

    a_out_after_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT) |-> (fin_reg && lendone_reg && pos_reg == 6'd0))
        else $error("digest emitted before length block compressed");
`endif

endmodule
